FILE: src/lobm_pkg.sv
`default_nettype none
package lobm_pkg;
  localparam int ORDERS_PER_SIDE = 32;
  localparam int CNT_W = $clog2(ORDERS_PER_SIDE + 1);

  localparam logic [1:0] KIND_TRADE   = 2'd0;
  localparam logic [1:0] KIND_RESTED  = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;
  localparam logic [1:0] KIND_DROPPED = 2'd3;

  typedef struct packed {
    logic [15:0] price;
    logic [31:0] quantity;
    logic [31:0] order_id;
    logic [31:0] owner;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic   shift_in;   // pop head: every cell takes its right neighbor
    logic   ins;        // insert new entry
    logic   dec;        // head quantity reduced
    logic [31:0] dec_qty;
    logic   sell_side;  // ordering rule: 1 asks (ascending)
    entry_t new_entry;
  } cell_ctl_t;
endpackage
`default_nettype wire

FILE: src/lobm_cell.sv
`default_nettype none
// One slot of a sorted chain. Inserts by comparing the new entry against its own entry.
module lobm_cell (
  input  wire logic               clk,
  input  wire lobm_pkg::cell_ctl_t ctl,
  input  wire logic               is_head,
  input  wire logic               left_valid,
  input  wire lobm_pkg::entry_t   left_entry,
  input  wire logic               left_goes_right,
  input  wire logic               my_valid,
  input  wire lobm_pkg::entry_t   right_entry,
  output lobm_pkg::entry_t        entry,
  output logic                    goes_right
);
  logic better;
  lobm_pkg::entry_t entry_next;

  // resting entry stays ahead of the new one unless the new price is strictly better
  always_comb begin
    if (ctl.sell_side) better = ctl.new_entry.price < entry.price;
    else better = ctl.new_entry.price > entry.price;
    goes_right = my_valid && (better || left_goes_right);
  end

  always_comb begin
    entry_next = entry;
    if (ctl.shift_in) begin
      entry_next = right_entry;
    end else if (ctl.ins) begin
      if (left_goes_right) entry_next = left_entry;
      else if ((!is_head && !left_valid) ? 1'b0 : 1'b1) begin
        if (goes_right || !my_valid) entry_next = ctl.new_entry;
      end
    end else if (ctl.dec && is_head) begin
      entry_next.quantity = entry.quantity - ctl.dec_qty;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end
endmodule
`default_nettype wire

FILE: src/lobm_chain.sv
`default_nettype none
// One side of the book as a row of cells, best entry at cell 0.
module lobm_chain (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire lobm_pkg::cell_ctl_t               ctl,
  output lobm_pkg::entry_t                       head,
  output logic [lobm_pkg::CNT_W-1:0]             count
);
  localparam int N = lobm_pkg::ORDERS_PER_SIDE;
  localparam int CNT_W = lobm_pkg::CNT_W;
  lobm_pkg::entry_t ent [N];
  logic [N-1:0] gr;
  logic [N-1:0] vld;

  always_comb begin
    for (int i = 0; i < N; i++) vld[i] = CNT_W'(i) < count;
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    lobm_cell u_cell (
      .clk            (clk),
      .ctl            (ctl),
      .is_head        (i == 0),
      .left_valid     ((i == 0) ? 1'b1 : vld[(i == 0) ? 0 : i - 1]),
      .left_entry     (ent[(i == 0) ? 0 : i - 1]),
      .left_goes_right((i == 0) ? 1'b0 : gr[(i == 0) ? 0 : i - 1]),
      .my_valid       (vld[i]),
      .right_entry    (ent[(i == N - 1) ? i : i + 1]),
      .entry          (ent[i]),
      .goes_right     (gr[i])
    );
  end

  assign head = ent[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.shift_in) begin
      count <= count - 1'b1;
    end else if (ctl.ins) begin
      count <= count + 1'b1;
    end
  end
endmodule
`default_nettype wire

FILE: src/limit_order_book_matcher_top.sv
`default_nettype none
// channel | dir | payload
// s_axis  | in  | side, price, quantity, order_id, client_id, ticker, timestamp
// m_axis  | out | kind, trade_id, ids, ticker, price, quantity, time; tlast = last
// The idle state takes an item; the match state makes each trade (head fill,
// plus pop shift) while the output is free, until the head no longer crosses;
// the final state gives the final result and the insert into the cell chain.
// Reset clears the counts and the trade counter; cell contents are left as is.
// A result waits in the output register; the sequencer holds while it is full.
module limit_order_book_matcher_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // side, price, quantity, order_id, client_id, ticker, timestamp, 7 pad
  input  wire logic [167:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // kind, trade_id, buy_order_id, sell_order_id, buy_client_id, sell_client_id,
  // trade_ticker, trade_price, fill_quantity, trade_time, 6 pad
  output logic [247:0]      m_axis_tdata,
  output logic              m_axis_tlast
);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0]  state;
  logic        side;
  logic [15:0] price, client_id, ticker;
  logic [31:0] qty, order_id, trade_counter;
  logic [47:0] ts;

  lobm_pkg::cell_ctl_t bid_ctl, ask_ctl;
  lobm_pkg::entry_t    bid_head, ask_head, opp;
  logic [lobm_pkg::CNT_W-1:0] bid_count, ask_count, opp_count, own_count;

  logic        out_free, crosses;
  logic [31:0] fill;
  lobm_pkg::entry_t new_entry;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign opp = side ? bid_head : ask_head;
  assign opp_count = side ? bid_count : ask_count;
  assign own_count = side ? ask_count : bid_count;
  assign crosses = (qty != 0) && (opp_count != 0) &&
                   (side ? (price <= opp.price) : (price >= opp.price));
  assign fill = (qty < opp.quantity) ? qty : opp.quantity;
  assign new_entry = '{price: price, quantity: qty, order_id: order_id,
                       owner: {ticker, client_id}};

  logic do_trade, do_final, rests;
  assign do_trade = (state == ST_MATCH) && crosses && out_free;
  assign do_final = (state == ST_FINAL) && out_free;
  assign rests = (qty != 0) && (own_count != lobm_pkg::CNT_W'(lobm_pkg::ORDERS_PER_SIDE));

  always_comb begin
    bid_ctl = '{shift_in: 1'b0, ins: 1'b0, dec: 1'b0, dec_qty: fill,
                sell_side: 1'b0, new_entry: new_entry};
    ask_ctl = '{shift_in: 1'b0, ins: 1'b0, dec: 1'b0, dec_qty: fill,
                sell_side: 1'b1, new_entry: new_entry};
    if (do_trade) begin
      if (side) begin
        bid_ctl.shift_in = (fill == opp.quantity);
        bid_ctl.dec = 1'b1;
      end else begin
        ask_ctl.shift_in = (fill == opp.quantity);
        ask_ctl.dec = 1'b1;
      end
    end
    if (do_final && rests) begin
      if (side) ask_ctl.ins = 1'b1;
      else bid_ctl.ins = 1'b1;
    end
  end

  lobm_chain u_bids (.clk(clk), .rst(rst), .ctl(bid_ctl), .head(bid_head), .count(bid_count));
  lobm_chain u_asks (.clk(clk), .rst(rst), .ctl(ask_ctl), .head(ask_head), .count(ask_count));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      trade_counter <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      m_axis_tvalid <= do_trade || do_final || (m_axis_tvalid && !m_axis_tready);
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            side      <= s_axis_tdata[0];
            price     <= s_axis_tdata[16:1];
            qty       <= s_axis_tdata[48:17];
            order_id  <= s_axis_tdata[80:49];
            client_id <= s_axis_tdata[96:81];
            ticker    <= s_axis_tdata[112:97];
            ts        <= s_axis_tdata[160:113];
            state     <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          if (!crosses) begin
            state <= ST_FINAL;
          end else if (out_free) begin
            m_axis_tlast  <= 1'b0;
            m_axis_tdata  <= {6'd0, ts, fill, opp.price, opp.owner[31:16],
                              side ? client_id : opp.owner[15:0],
                              side ? opp.owner[15:0] : client_id,
                              side ? order_id : opp.order_id,
                              side ? opp.order_id : order_id,
                              trade_counter, lobm_pkg::KIND_TRADE};
            trade_counter <= trade_counter + 1'b1;
            qty <= qty - fill;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            m_axis_tlast  <= 1'b1;
            m_axis_tdata  <= {6'd0, ts, qty, price, ticker,
                              side ? client_id : 16'd0,
                              side ? 16'd0 : client_id,
                              side ? order_id : 32'd0,
                              side ? 32'd0 : order_id,
                              32'd0,
                              (qty == 0) ? lobm_pkg::KIND_NONE :
                              rests ? lobm_pkg::KIND_RESTED : lobm_pkg::KIND_DROPPED};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
